// File: rtl/core/lkvc_pkg.sv
// lkvc_pkg: shared types and constants for the lru key-value cache
// depends on nothing
`default_nettype none
package lkvc_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/lkvc_datapath.sv
// lkvc_datapath: slot storage, key match, rank update and result register
// depends on lkvc_pkg
`default_nettype none
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic [CAP_W-1:0]   cap,
    input  wire logic               req_type,
    input  wire logic signed [31:0] lookup_key,
    input  wire logic signed [31:0] write_value,
    output logic                    key_found,
    output logic signed [31:0]      read_value,
    output logic                    evicted,
    output logic signed [31:0]      evicted_key
);
    localparam int IW = $clog2(ENTRIES);
    localparam int RW = $clog2(ENTRIES);
    localparam int FW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] valid_reg;
    logic [RW-1:0]      rank_reg [ENTRIES];
    logic [31:0]        key_mem  [ENTRIES];
    logic [31:0]        val_mem  [ENTRIES];
    logic [FW-1:0]      fill_reg;

    logic        put_reg;
    logic [31:0] key_reg, wval_reg;
    logic        found_reg, ev_reg;
    logic [31:0] rd_reg, evkey_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            put_reg  <= req_type;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
    end

    // effective capacity
    logic [FW-1:0] eff_cap;
    always_comb
    begin
        if (cap == '0)
            eff_cap = FW'(1);
        else if (32'(cap) > ENTRIES)
            eff_cap = FW'(ENTRIES);
        else
            eff_cap = FW'(cap);
    end

    // key match, first free, least recent
    logic [ENTRIES-1:0] hit_vec;
    logic          hit;
    logic [IW-1:0] hit_idx, free_idx, lru_idx;
    logic          free_ok;
    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        free_ok = 1'b0;
        free_idx = '0;
        lru_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_mem[i] == key_reg);
            // lru is the unique valid slot of rank fill-1
            if (valid_reg[i] && (FW'(rank_reg[i]) == fill_reg - FW'(1)))
                lru_idx = IW'(i);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // slot choice and promotion limit
    logic          do_write, do_promote, insert;
    logic [IW-1:0] tgt;
    logic [RW-1:0] limit;
    logic          limit_all;
    always_comb
    begin
        insert = 1'b0;
        do_write = 1'b0;
        do_promote = 1'b0;
        tgt = hit_idx;
        limit_all = 1'b0;
        limit = rank_reg[hit_idx];
        if (hit)
        begin
            do_promote = 1'b1;
            do_write = put_reg;
        end
        else if (put_reg)
        begin
            do_write = 1'b1;
            do_promote = 1'b1;
            if (fill_reg < eff_cap && free_ok)
            begin
                insert = 1'b1;
                tgt = free_idx;
                limit_all = 1'b1;
            end
            else
            begin
                tgt = lru_idx;
                limit = rank_reg[lru_idx];
            end
        end
    end

    // state update and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else if (cmd.execute && do_promote)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IW'(i) == tgt)
                    rank_reg[i] <= '0;
                else if (valid_reg[i] && (limit_all || rank_reg[i] < limit))
                    rank_reg[i] <= rank_reg[i] + RW'(1);
            end
            if (insert)
            begin
                valid_reg[tgt] <= 1'b1;
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            found_reg <= hit;
            rd_reg    <= (hit && !put_reg) ? val_mem[hit_idx] : MISS_VALUE;
            ev_reg    <= put_reg && !hit && !insert;
            evkey_reg <= (put_reg && !hit && !insert) ? key_mem[lru_idx] : '0;
            if (do_write)
            begin
                key_mem[tgt] <= key_reg;
                val_mem[tgt] <= wval_reg;
            end
        end
    end

    assign stat.busy   = 1'b0;
    assign key_found   = found_reg;
    assign read_value  = rd_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evkey_reg;
endmodule
`default_nettype wire

// File: rtl/core/lkvc_ctrl.sv
// lkvc_ctrl: request sequencing and output handshake
// depends on lkvc_pkg
`default_nettype none
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);
    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.busy)
                begin
                    cmd.execute = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/lru_key_value_cache.sv
// lru_key_value_cache: top level joining controller and datapath
// depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement.
// One request is handled at a time: capture, then parallel key compare
// and rank update, then the result beat is offered; no new request is
// taken until that result beat has been accepted.
// The store is empty after reset with no clearing pass.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CAP_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic signed [31:0] lookup_key,
    input  wire logic signed [31:0] write_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    key_found,
    output logic signed [31:0]      read_value,
    output logic                    evicted,
    output logic signed [31:0]      evicted_key
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [CAP_W-1:0] cap_reg;

    // capacity register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid)
            cap_reg <= cfg_data;
    end

    lkvc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    lkvc_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .cap(cap_reg),
        .req_type(req_type), .lookup_key(lookup_key), .write_value(write_value),
        .key_found(key_found), .read_value(read_value), .evicted(evicted),
        .evicted_key(evicted_key)
    );

`ifndef SYNTHESIS
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_evict_needs_put: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> (!key_found && read_value == MISS_VALUE))
        else $error("eviction on hit or get");
    a_accept_leads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ##1 out_valid) else $error("result missing");
`endif
endmodule
`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for lru_key_value_cache
// depends on lkvc_pkg and the lru_key_value_cache rtl
`default_nettype none

// scoreboard: shadow lru store plus queue of expected result beats
class lru_scoreboard;
    typedef struct {
        logic        found;
        logic [31:0] rd;
        logic        ev;
        logic [31:0] evkey;
    } lru_result_t;

    bit          valid_q [16];
    logic [31:0] key_q [16];
    logic [31:0] val_q [16];
    int unsigned rank_q [16];
    int unsigned fill;
    int unsigned capacity;
    lru_result_t pending [$];
    int          errors;
    int          checked;
    int          evictions;
    int          hits;

    function new();
        capacity = 16;
        fill = 0;
        errors = 0;
        checked = 0;
        evictions = 0;
        hits = 0;
        foreach (valid_q[i])
        begin
            valid_q[i] = 0;
            rank_q[i] = 0;
            key_q[i] = '0;
            val_q[i] = '0;
        end
    endfunction

    function void set_capacity(logic [4:0] c);
        capacity = c;
    endfunction

    // bump younger entries and make slot s most recent
    function void make_recent(int s, int unsigned limit);
        foreach (valid_q[i])
            if (i != s && valid_q[i] && rank_q[i] < limit)
                rank_q[i]++;
        rank_q[s] = 0;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic is_put, logic [31:0] k, logic [31:0] v);
        lru_result_t r;
        int s;
        int t;
        int unsigned cap;
        s = -1;
        t = -1;
        r.found = 0;
        r.rd = lkvc_pkg::MISS_VALUE;
        r.ev = 0;
        r.evkey = '0;
        cap = (capacity < 1) ? 1 : (capacity > 16 ? 16 : capacity);
        for (int i = 0; i < 16; i++)
            if (s < 0 && valid_q[i] && key_q[i] == k)
                s = i;
        if (s >= 0)
        begin
            r.found = 1;
            hits++;
        end
        if (is_put == lkvc_pkg::REQ_GET)
        begin
            if (s >= 0)
            begin
                r.rd = val_q[s];
                make_recent(s, rank_q[s]);
            end
        end
        else if (s >= 0)
        begin
            val_q[s] = v;
            make_recent(s, rank_q[s]);
        end
        else
        begin
            if (fill < cap)
                for (int i = 0; i < 16; i++)
                    if (t < 0 && !valid_q[i])
                        t = i;
            if (t >= 0)
            begin
                valid_q[t] = 1;
                key_q[t] = k;
                val_q[t] = v;
                make_recent(t, 32'hFFFF_FFFF);
                fill++;
            end
            else
            begin
                for (int i = 0; i < 16; i++)
                    if (valid_q[i] && (t < 0 || rank_q[i] > rank_q[t]))
                        t = i;
                if (t >= 0)
                begin
                    r.ev = 1;
                    r.evkey = key_q[t];
                    evictions++;
                    key_q[t] = k;
                    val_q[t] = v;
                    make_recent(t, rank_q[t]);
                end
            end
        end
        pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic f, logic [31:0] rd, logic e, logic [31:0] ek);
        lru_result_t x;
        if (pending.size() == 0)
        begin
            report_error("result beat with nothing expected");
            return;
        end
        x = pending.pop_front();
        checked++;
        if (f !== x.found)
            report_error($sformatf("key_found %0b, expected %0b", f, x.found));
        if (rd !== x.rd)
            report_error($sformatf("read_value %h, expected %h", rd, x.rd));
        if (e !== x.ev)
            report_error($sformatf("evicted %0b, expected %0b", e, x.ev));
        if (ek !== x.evkey)
            report_error($sformatf("evicted_key %h, expected %h", ek, x.evkey));
    endfunction

    function void report_error(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s", checked, msg);
    endfunction
endclass

module tb;
    import lkvc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
    logic               out_valid;
    logic               out_stall;
    logic               key_found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;

    lru_scoreboard sb;
    int            cycles;
    logic [31:0]   key_pool [8];

    lru_key_value_cache uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_found   (key_found),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("lru_key_value_cache test failed");
            $finish;
        end
    end

    // result side: random stall per beat, check on acceptance
    initial
    begin
        int gap;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_stall <= 1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(key_found, read_value, evicted, evicted_key);
        end
    end

    // one request beat, random gap first; valid stays up until the next gap
    task automatic send_request(logic is_put, logic [31:0] k, logic [31:0] v,
                                bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1;
        req_type    <= is_put;
        lookup_key  <= k;
        write_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(is_put, k, v);
    endtask

    // wait for the block to drain, then write the capacity
    task automatic write_capacity(logic [CAP_W-1:0] c);
        wait_drain();
        cfg_valid <= 1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        sb.set_capacity(c);
    endtask

    task automatic wait_drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random key: mostly from a small pool so hits and evictions are common
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 3);
        return $urandom();
    endfunction

    task automatic random_phase(int n);
        bit burst;
        for (int i = 0; i < n; i++)
        begin
            burst = (i % 100) < 20;
            send_request($urandom_range(0, 1), pick_key(), $urandom(), burst);
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps [8];
        cycles      = 0;
        rst_n       = 0;
        cfg_valid   = 0;
        cfg_data    = '0;
        in_valid    = 0;
        req_type    = REQ_GET;
        lookup_key  = '0;
        write_value = '0;
        sb = new();
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFC;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: miss on empty, extremes, update, fill and evict at 16
        send_request(REQ_GET, 32'h0, 32'h0, 0);
        send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(REQ_GET, 32'h8000_0000, 32'h0, 0);
        send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 0);
        send_request(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        for (int i = 0; i < 15; i++)
            send_request(REQ_PUT, 32'h100 + i, i, 0);
        send_request(REQ_GET, 32'hDEAD_BEEF, 32'h0, 0);

        // capacity lowered below fill: every new put evicts, fill stays
        write_capacity(5'd1);
        send_request(REQ_PUT, 32'h55AA_55AA, 32'h1, 0);
        send_request(REQ_PUT, 32'hAA55_AA55, 32'h2, 0);
        random_phase(225);

        // zero acts as one; large values saturate
        caps = '{5'd0, 5'd31, 5'd2, 5'd17, 5'd3, 5'd8, 5'd16, 5'd1};
        foreach (caps[i])
        begin
            write_capacity(caps[i]);
            random_phase(200);
        end
        wait_drain();

        repeat (20) @(posedge clk);
        $display("%0d requests checked: %0d hits, %0d evictions, 9 capacity settings",
                 sb.checked, sb.hits, sb.evictions);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("lru_key_value_cache test passed");
        else
            $display("lru_key_value_cache test failed");
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_datapath.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lru_key_value_cache.sv
tb/tb.sv
